FILE: sv/scce_pkg.sv
// Shared types and constants of the serial camera command engine.
// Used by the front, queue, back and top-level modules; depends on nothing.
package scce_pkg;

  localparam int REPLY_DEPTH = 16;
  localparam int REPLY_FRAME = 8;
  localparam int CMD_BYTES = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam logic [7:0] SYNC_VALUE = 8'hFF;
  localparam logic [15:0] REPLY_ACK_POS = 16'd3;
  localparam logic [15:0] REPLY_ECHO_POS = 16'd4;

  localparam logic [1:0] REG_ACK_CODE = 2'd0;
  localparam logic [1:0] REG_NAK_CODE = 2'd1;
  localparam logic [1:0] REG_WAIT_TICKS = 2'd2;
  localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    OP_ISSUE = 2'd0,
    OP_RX    = 2'd1,
    OP_TICK  = 2'd2,
    OP_ARM   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_TX      = 2'd0,
    RES_CAPTURE = 2'd1,
    RES_ACK     = 2'd2,
    RES_FAIL    = 2'd3
  } res_kind_t;

  typedef enum logic [2:0] {
    JOB_FRAME     = 3'd0,
    JOB_FRAME_ACK = 3'd1,
    JOB_CAPTURE   = 3'd2,
    JOB_ACK       = 3'd3,
    JOB_FAIL      = 3'd4
  } job_kind_t;

  typedef struct packed {
    job_kind_t                        kind;
    logic [CMD_BYTES-1:0][7:0]        bytes;
  } job_t;

  typedef struct packed {
    logic [7:0] ack_code;
    logic [7:0] nak_code;
    logic [7:0] wait_ticks;
    logic [3:0] attempt_limit;
  } cfg_t;

endpackage

FILE: sv/scce_front.sv
// Front end: accepts input items, keeps the command and reply state and
// turns each item into at most one job for the back end. Uses scce_pkg.
module scce_front (
  input  logic                clk,
  input  logic                rst_n,
  input  scce_pkg::cfg_t      cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [79:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                q_full,
  output logic                push_valid,
  output scce_pkg::job_t      push_job
);
  import scce_pkg::*;

  logic [CMD_BYTES-1:0][7:0] cmd_r, cmd_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [3:0]  attempts_r, attempts_nxt;
  logic [7:0]  ticks_r, ticks_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  reply3_r, reply3_nxt;
  logic [7:0]  reply4_r, reply4_nxt;

  logic        accept;
  op_t         op;
  logic [CMD_BYTES-1:0][7:0] cmd_in;
  logic [7:0]  rx_byte;
  logic [15:0] window_offset;
  logic [15:0] window_length;
  logic [7:0]  wait_load;
  logic [7:0]  tick_dec;
  logic        do_retry;

  assign in_tready     = !q_full;
  assign accept        = in_tvalid && in_tready;
  assign op            = op_t'(in_tuser);
  assign cmd_in        = in_tdata[39:0];
  assign rx_byte       = in_tdata[47:40];
  assign window_offset = in_tdata[63:48];
  assign window_length = in_tdata[79:64];
  assign wait_load     = (cfg.wait_ticks == 8'd0) ? 8'd1 : cfg.wait_ticks;
  assign tick_dec      = (ticks_r != 8'd0) ? ticks_r - 8'd1 : 8'd0;

  always_comb begin
    cmd_nxt       = cmd_r;
    awaiting_nxt  = awaiting_r;
    attempts_nxt  = attempts_r;
    ticks_nxt     = ticks_r;
    skip_nxt      = skip_r;
    cap_nxt       = cap_r;
    count_nxt     = count_r;
    reply3_nxt    = reply3_r;
    reply4_nxt    = reply4_r;
    push_valid    = 1'b0;
    push_job.kind = JOB_ACK;
    push_job.bytes = cmd_r;
    do_retry      = 1'b0;
    if (accept) begin
      unique case (op)
        OP_ISSUE: begin
          cmd_nxt        = cmd_in;
          count_nxt      = '0;
          push_valid     = 1'b1;
          push_job.bytes = cmd_in;
          if (cmd_in[0] == cfg.ack_code || cmd_in[0] == cfg.nak_code) begin
            awaiting_nxt  = 1'b0;
            push_job.kind = JOB_FRAME_ACK;
          end else begin
            awaiting_nxt  = 1'b1;
            attempts_nxt  = (cfg.attempt_limit != 4'd0) ? cfg.attempt_limit - 4'd1 : 4'd0;
            ticks_nxt     = wait_load;
            push_job.kind = JOB_FRAME;
          end
        end
        OP_RX: begin
          if (count_r < 16'(REPLY_DEPTH)) begin
            if (count_r == REPLY_ACK_POS) begin
              reply3_nxt = rx_byte;
            end
            if (count_r == REPLY_ECHO_POS) begin
              reply4_nxt = rx_byte;
            end
          end else if (skip_r != 16'd0) begin
            skip_nxt = skip_r - 16'd1;
          end else if (cap_r != 16'd0) begin
            cap_nxt           = cap_r - 16'd1;
            push_valid        = 1'b1;
            push_job.kind     = JOB_CAPTURE;
            push_job.bytes[0] = rx_byte;
          end
          if (count_r != 16'hFFFF) begin
            count_nxt = count_r + 16'd1;
          end
        end
        OP_TICK: begin
          if (awaiting_r) begin
            if (count_r >= 16'(REPLY_FRAME)) begin
              if (reply3_r == cfg.ack_code && reply4_r == cmd_r[0]) begin
                awaiting_nxt  = 1'b0;
                push_valid    = 1'b1;
                push_job.kind = JOB_ACK;
              end else begin
                do_retry = 1'b1;
              end
            end else begin
              ticks_nxt = tick_dec;
              do_retry  = (tick_dec == 8'd0);
            end
            if (do_retry) begin
              push_valid = 1'b1;
              if (attempts_r == 4'd0) begin
                awaiting_nxt  = 1'b0;
                push_job.kind = JOB_FAIL;
              end else begin
                attempts_nxt  = attempts_r - 4'd1;
                ticks_nxt     = wait_load;
                count_nxt     = '0;
                push_job.kind = JOB_FRAME;
              end
            end
          end
        end
        OP_ARM: begin
          skip_nxt = window_offset;
          cap_nxt  = window_length;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= '0;
      awaiting_r <= 1'b0;
      attempts_r <= '0;
      ticks_r    <= '0;
      skip_r     <= '0;
      cap_r      <= '0;
      count_r    <= '0;
      reply3_r   <= '0;
      reply4_r   <= '0;
    end else begin
      cmd_r      <= cmd_nxt;
      awaiting_r <= awaiting_nxt;
      attempts_r <= attempts_nxt;
      ticks_r    <= ticks_nxt;
      skip_r     <= skip_nxt;
      cap_r      <= cap_nxt;
      count_r    <= count_nxt;
      reply3_r   <= reply3_nxt;
      reply4_r   <= reply4_nxt;
    end
  end

endmodule

FILE: sv/scce_queue.sv
// Short job queue between the front and back ends.
// Uses scce_pkg for the job type and depth.
module scce_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  scce_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output scce_pkg::job_t head_job
);
  import scce_pkg::*;

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/scce_back.sv
// Back end: expands each job into result items, one per cycle unless
// stalled, into an output register. Uses scce_pkg job and result types.
module scce_back #(
  parameter int SYNC_BYTES = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  scce_pkg::job_t head_job,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic [1:0]     out_tuser,
  output logic           out_tlast
);
  import scce_pkg::*;

  localparam int IW = $clog2(SYNC_BYTES + CMD_BYTES + 1);
  localparam logic [IW-1:0] SYNC_END  = IW'(SYNC_BYTES);
  localparam logic [IW-1:0] FRAME_END = IW'(SYNC_BYTES + CMD_BYTES);

  job_t          cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  res_kind_t     out_kind_r, out_kind_nxt;
  logic          out_last_r, out_last_nxt;

  logic          emit;
  logic          is_last;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] byte_sel;
  logic [7:0]    cmd_byte;
  res_kind_t     res_kind;
  logic [7:0]    res_data;

  assign byte_sel = idx_r - SYNC_END;

  always_comb begin
    unique case (byte_sel[2:0])
      3'd0:    cmd_byte = cur_r.bytes[0];
      3'd1:    cmd_byte = cur_r.bytes[1];
      3'd2:    cmd_byte = cur_r.bytes[2];
      3'd3:    cmd_byte = cur_r.bytes[3];
      3'd4:    cmd_byte = cur_r.bytes[4];
      default: cmd_byte = 8'd0;
    endcase
  end

  always_comb begin
    last_idx = '0;
    res_kind = RES_ACK;
    res_data = 8'd0;
    unique case (cur_r.kind)
      JOB_FRAME, JOB_FRAME_ACK: begin
        last_idx = (cur_r.kind == JOB_FRAME_ACK) ? FRAME_END : FRAME_END - 1'b1;
        if (idx_r < SYNC_END) begin
          res_kind = RES_TX;
          res_data = SYNC_VALUE;
        end else if (idx_r < FRAME_END) begin
          res_kind = RES_TX;
          res_data = cmd_byte;
        end
      end
      JOB_CAPTURE: begin
        res_kind = RES_CAPTURE;
        res_data = cur_r.bytes[0];
      end
      JOB_ACK:  res_kind = RES_ACK;
      JOB_FAIL: res_kind = RES_FAIL;
      default:  res_kind = RES_FAIL;
    endcase
  end

  assign emit    = cur_valid_r && (!out_valid_r || out_tready);
  assign is_last = (idx_r == last_idx);
  assign pop     = head_valid && (!cur_valid_r || (emit && is_last));

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (emit) begin
      idx_nxt = idx_r + 1'b1;
      if (is_last) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (pop) begin
      cur_nxt       = head_job;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
      out_kind_nxt  = res_kind;
      out_last_nxt  = is_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
    idx_r      <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: sv/serial_camera_command_engine.sv
// Serial camera command engine: APB registers, front end, job queue, back end.
// Every input item is accepted whenever the job queue has room.
// A command frame leaves as SYNC_BYTES+5 result items (one more for an
// immediate acknowledge), one per cycle from the back-end sequencer unless
// the output stalls; other jobs give one item. Outputs are registered.
// Synchronous active-low reset clears control state, loads register defaults.
module serial_camera_command_engine #(
  parameter int SYNC_BYTES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode, arg1, arg2, arg3, arg4, rx_byte, window_offset, window_length
  input  logic [79:0] in_tdata,
  // operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // data_byte
  output logic [7:0]  out_tdata,
  // result_kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import scce_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cfg_we;
  logic push_valid;
  job_t push_job;
  logic q_full;
  logic pop;
  logic head_valid;
  job_t head_job;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_paddr[3:2])
        REG_ACK_CODE:      cfg_nxt.ack_code      = cfg_pwdata[7:0];
        REG_NAK_CODE:      cfg_nxt.nak_code      = cfg_pwdata[7:0];
        REG_WAIT_TICKS:    cfg_nxt.wait_ticks    = cfg_pwdata[7:0];
        REG_ATTEMPT_LIMIT: cfg_nxt.attempt_limit = cfg_pwdata[3:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ACK_CODE:      cfg_prdata = {24'd0, cfg_r.ack_code};
      REG_NAK_CODE:      cfg_prdata = {24'd0, cfg_r.nak_code};
      REG_WAIT_TICKS:    cfg_prdata = {24'd0, cfg_r.wait_ticks};
      REG_ATTEMPT_LIMIT: cfg_prdata = {28'd0, cfg_r.attempt_limit};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_code      <= 8'd14;
      cfg_r.nak_code      <= 8'd15;
      cfg_r.wait_ticks    <= 8'd100;
      cfg_r.attempt_limit <= 4'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  scce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  scce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  scce_back #(
    .SYNC_BYTES (SYNC_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for serial_camera_command_engine: a scoreboard class
// predicts every transmit, capture, acknowledge and failure item of the engine.
// Depends on scce_pkg and the engine RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scce_pkg::*;

  localparam int SYNC_COUNT = 3;
  localparam int RUN_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 20;

  typedef struct {
    res_kind_t  kind;
    logic [7:0] data;
    logic       is_end;
  } link_result_t;

  class link_scoreboard;
    logic [7:0]  ack_code = 8'd14;
    logic [7:0]  nak_code = 8'd15;
    logic [7:0]  wait_ticks = 8'd100;
    logic [3:0]  attempt_limit = 4'd8;
    logic [7:0]  reply_store [REPLY_DEPTH];
    logic [7:0]  cmd [CMD_BYTES];
    logic [15:0] reply_count;
    logic [15:0] skip_left;
    logic [15:0] capture_left;
    logic        awaiting;
    logic [3:0]  attempts_left;
    logic [7:0]  ticks_left;
    link_result_t due_results[$];
    int mismatches;

    function new();
      foreach (reply_store[i]) reply_store[i] = 8'd0;
      foreach (cmd[i]) cmd[i] = 8'd0;
      reply_count = '0;
      skip_left = '0;
      capture_left = '0;
      awaiting = 1'b0;
      attempts_left = '0;
      ticks_left = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_ACK_CODE: ack_code = value[7:0];
        REG_NAK_CODE: nak_code = value[7:0];
        REG_WAIT_TICKS: wait_ticks = value[7:0];
        REG_ATTEMPT_LIMIT: attempt_limit = value[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void emit(res_kind_t k, logic [7:0] d);
      due_results.push_back('{kind: k, data: d, is_end: 1'b0});
    endfunction

    function logic [7:0] reload_ticks();
      return (wait_ticks == 8'd0) ? 8'd1 : wait_ticks;
    endfunction

    function void send_frame();
      reply_count = '0;
      for (int i = 0; i < SYNC_COUNT; i++) emit(RES_TX, SYNC_VALUE);
      for (int i = 0; i < CMD_BYTES; i++) emit(RES_TX, cmd[i]);
    endfunction

    function void resend_or_fail();
      if (attempts_left == 4'd0) begin
        awaiting = 1'b0;
        emit(RES_FAIL, 8'd0);
      end else begin
        attempts_left = attempts_left - 4'd1;
        ticks_left = reload_ticks();
        send_frame();
      end
    endfunction

    function void accept_item(op_t op, logic [79:0] d);
      int prior_count;
      logic [7:0] b;
      prior_count = due_results.size();
      b = d[47:40];
      case (op)
        OP_ISSUE: begin
          for (int i = 0; i < CMD_BYTES; i++) cmd[i] = d[8*i +: 8];
          awaiting = 1'b0;
          send_frame();
          if (cmd[0] == ack_code || cmd[0] == nak_code) begin
            emit(RES_ACK, 8'd0);
          end else begin
            awaiting = 1'b1;
            attempts_left = (attempt_limit == 4'd0) ? 4'd0 : attempt_limit - 4'd1;
            ticks_left = reload_ticks();
          end
        end
        OP_RX: begin
          if (reply_count < REPLY_DEPTH) begin
            reply_store[reply_count[3:0]] = b;
          end else if (skip_left != 16'd0) begin
            skip_left = skip_left - 16'd1;
          end else if (capture_left != 16'd0) begin
            capture_left = capture_left - 16'd1;
            emit(RES_CAPTURE, b);
          end
          if (reply_count != 16'hFFFF) reply_count = reply_count + 16'd1;
        end
        OP_TICK: begin
          if (awaiting) begin
            if (reply_count >= REPLY_FRAME) begin
              if (reply_store[REPLY_ACK_POS[3:0]] == ack_code &&
                  reply_store[REPLY_ECHO_POS[3:0]] == cmd[0]) begin
                awaiting = 1'b0;
                emit(RES_ACK, 8'd0);
              end else begin
                resend_or_fail();
              end
            end else begin
              if (ticks_left != 8'd0) ticks_left = ticks_left - 8'd1;
              if (ticks_left == 8'd0) resend_or_fail();
            end
          end
        end
        OP_ARM: begin
          skip_left = d[63:48];
          capture_left = d[79:64];
        end
        default: ;
      endcase
      if (due_results.size() > prior_count) due_results[due_results.size()-1].is_end = 1'b1;
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic is_end);
      link_result_t want;
      if (due_results.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected item: kind %0d data %02h last %0b", kind, data, is_end);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (want.kind !== kind || want.data !== data || want.is_end !== is_end) begin
        if (mismatches < 10)
          $display("Mismatch: expected kind %0d data %02h last %0b, got kind %0d data %02h last %0b",
                   want.kind, want.data, want.is_end, kind, data, is_end);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  link_scoreboard book = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  serial_camera_command_engine #(.SYNC_BYTES(SYNC_COUNT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) book.check_result(out_tuser, out_tdata, out_tlast);
    if (cycle_count >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [79:0] rand80();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[79:0];
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    book.set_reg(idx, value);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [7:0] ack, logic [7:0] nak, logic [7:0] ticks,
                           logic [3:0] limit);
    write_reg(REG_ACK_CODE, {24'd0, ack});
    write_reg(REG_NAK_CODE, {24'd0, nak});
    write_reg(REG_WAIT_TICKS, {24'd0, ticks});
    write_reg(REG_ATTEMPT_LIMIT, {28'd0, limit});
  endtask

  task automatic send_item(op_t op, logic [79:0] payload);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= payload;
    do @(posedge clk); while (!in_tready);
    book.accept_item(op, payload);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic issue_cmd(logic [7:0] opcode, logic [31:0] args);
    logic [79:0] p;
    p = rand80();
    p[39:0] = {args, opcode};
    send_item(OP_ISSUE, p);
  endtask

  task automatic feed_byte(logic [7:0] b);
    logic [79:0] p;
    p = rand80();
    p[47:40] = b;
    send_item(OP_RX, p);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, rand80());
  endtask

  task automatic arm_window(logic [15:0] offset, logic [15:0] length);
    logic [79:0] p;
    p = rand80();
    p[79:48] = {length, offset};
    send_item(OP_ARM, p);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One command with a reply that is mostly well formed, sometimes short or corrupt.
  task automatic exchange();
    logic [7:0] opc;
    logic [7:0] b;
    int roll;
    int nrx;
    bit good;
    roll = $urandom_range(0, 9);
    opc = (roll == 0) ? book.ack_code : (roll == 1) ? book.nak_code : 8'($urandom);
    good = ($urandom_range(0, 4) != 0);
    issue_cmd(opc, $urandom);
    if ($urandom_range(0, 3) == 0) arm_window(16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)));
    nrx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 26);
    for (int i = 0; i < nrx; i++) begin
      b = 8'($urandom);
      if (good && i == REPLY_ACK_POS) b = book.ack_code;
      if (good && i == REPLY_ECHO_POS) b = opc;
      feed_byte(b);
      if ($urandom_range(0, 9) == 0) send_tick();
    end
    repeat ($urandom_range(1, 3)) send_tick();
  endtask

  task automatic random_traffic(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 4) != 0) begin
        exchange();
      end else begin
        send_item(op_t'($urandom_range(0, 3)), rand80());
      end
    end
  endtask

  // Long reply: bytes past the reply store are skipped, then captured, and the
  // stored reply stays intact for the acknowledge check.
  task automatic reply_flood();
    logic [7:0] b;
    issue_cmd(8'h21, $urandom);
    arm_window(16'd4, 16'd3);
    for (int i = 0; i < 24; i++) begin
      b = 8'(i);
      if (i == REPLY_ACK_POS) b = book.ack_code;
      if (i == REPLY_ECHO_POS) b = 8'h21;
      feed_byte(b);
    end
    send_tick();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    issue_cmd(8'd14, 32'h0000_0000);
    issue_cmd(8'd15, 32'hFFFF_FFFF);
    send_tick();
    arm_window(16'hFFFF, 16'hFFFF);
    arm_window(16'h0000, 16'h0000);
    issue_cmd(8'hFF, 32'h1234_5678);
    feed_byte(8'h00);
    feed_byte(8'hFF);
    feed_byte(8'h55);
    feed_byte(8'd14);
    feed_byte(8'hFF);
    feed_byte(8'hAA);
    feed_byte(8'h01);
    feed_byte(8'h02);
    send_tick();
    issue_cmd(8'h00, 32'hA5A5_5A5A);
    feed_byte(8'h0E);
    feed_byte(8'h00);
    send_tick();
    issue_cmd(8'h3C, 32'h5A5A_A5A5);
    send_tick();
    drain();

    configure(8'h00, 8'hFF, 8'd1, 4'd1);
    issue_cmd(8'h80, $urandom);
    send_tick();
    random_traffic(PHASE_ITEMS);
    drain();

    idle_pct = 54;
    configure(8'hFF, 8'h00, 8'd0, 4'd0);
    issue_cmd(8'h80, $urandom);
    send_tick();
    random_traffic(PHASE_ITEMS);
    drain();

    idle_pct = 0;
    stall_pct = 54;
    configure(8'($urandom), 8'($urandom), 8'd3, 4'd15);
    random_traffic(PHASE_ITEMS);
    drain();

    idle_pct = 19;
    stall_pct = 19;
    configure(8'd14, 8'd15, 8'd255, 4'd2);
    random_traffic(PHASE_ITEMS);
    drain();

    idle_pct = 0;
    reply_flood();
    drain();

    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/scce_pkg.sv
sv/scce_front.sv
sv/scce_queue.sv
sv/scce_back.sv
sv/serial_camera_command_engine.sv
dv/tb_top.sv
